>>> src/dll_pkg.sv
package dll_pkg;

  localparam int MODE_W = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_SEARCH     = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_SRCH,
    S_INS_RD,
    S_INS_ALLOC,
    S_INS_LINK,
    S_UNL_RD,
    S_UNL_FIX,
    S_RESP
  } state_t;

endpackage

>>> src/dll_ifs.sv
interface dll_in_if;
  import dll_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output mode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input mode, input position, input item_value,
                  output ready);
endinterface

interface dll_out_if;
  import dll_pkg::*;
  logic             valid;
  logic             ready;
  logic             ok;
  logic             found;
  logic [CNT_W-1:0] count;

  modport source (output valid, output ok, output found, output count, input ready);
  modport sink   (input valid, input ok, input found, input count, output ready);
endinterface

>>> src/doubly_linked_list_engine.sv
// Channel   Direction  Beat contents
// in_ch     sink       mode, position, item_value
// out_ch    source     ok, found, count
//
// One request is handled at a time; in_ch is ready only while the engine is idle.
// After the accepting edge a push steps S_INS_RD, S_INS_ALLOC, S_INS_LINK, a pop
// S_UNL_RD, S_UNL_FIX; insert (not at the count) and remove at p first walk to p,
// and search walks the list, one link read per cycle. Then comes the response beat.
// Reset is synchronous and needs no clearing pass: a low-water mark stands in for
// the untouched part of the free stack. The response holds until taken.
module doubly_linked_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic  clk,
  input logic  rst_n,
  dll_in_if.sink    in_ch,
  dll_out_if.source out_ch
);
  import dll_pkg::*;

  // Node numbers index the pool; pointers carry one more code, the null link.
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] NULL_P = PW'(CAPACITY);

  // The pool: values, forward links and backward links, plus the free stack.
  logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
  logic [PW-1:0]         nxt_mem [CAPACITY];
  logic [PW-1:0]         prv_mem [CAPACITY];
  logic [AW-1:0]         stk_mem [CAPACITY];

  logic [DATA_WIDTH-1:0] val_q;
  logic [PW-1:0]         nxt_q, prv_q;
  logic [AW-1:0]         stk_q;

  state_t state_r, state_nxt;
  op_t    mode_r, mode_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [PW-1:0] cur_r, cur_nxt, i_r, i_nxt, bef_r, bef_nxt;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0] ft_r, ft_nxt, lw_r, lw_nxt, cnt_r, cnt_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic first_r, first_nxt, ok_r, ok_nxt, found_r, found_nxt;

  logic [AW-1:0] rd_addr, stk_rd_addr;
  logic val_we, nxt_we, prv_we, stk_we;
  logic [AW-1:0] val_wa, nxt_wa, prv_wa, stk_wa;
  logic [PW-1:0] nxt_wd, prv_wd;
  logic [AW-1:0] stk_wd;

  // Shared decode of the offered request and of the walk.
  op_t in_op;
  logic accept, req_fail, at_end, walk_hit;
  logic [CMPW-1:0] pos_in_x, pos_r_x, cnt_x, i_x;
  logic [PW-1:0] cur_eff, top, bef_link, after;
  logic [AW-1:0] new_node;

  assign in_op    = op_t'(in_ch.mode);
  assign accept   = in_ch.valid && in_ch.ready;
  assign pos_in_x = CMPW'(in_ch.position);
  assign pos_r_x  = CMPW'(pos_r);
  assign cnt_x    = CMPW'(cnt_r);
  assign i_x      = CMPW'(i_r);
  assign at_end   = (pos_in_x == cnt_x);
  assign walk_hit = (i_x == pos_r_x);
  // Once a walk has issued a read, the next node is the link just read.
  assign cur_eff  = first_r ? cur_r : nxt_q;
  assign top      = ft_r - PW'(1);
  assign new_node = (top < lw_r) ? top[AW-1:0] : stk_q;
  assign bef_link = (cur_r < NULL_P) ? prv_q : tail_r;
  assign after    = nxt_q;

  always_comb begin
    case (in_op)
      OP_PUSH_FRONT, OP_PUSH_BACK: req_fail = (ft_r == '0);
      OP_POP_FRONT, OP_POP_BACK:   req_fail = (cnt_r == '0);
      OP_INSERT:                   req_fail = (ft_r == '0) || (pos_in_x > cnt_x);
      OP_REMOVE:                   req_fail = (pos_in_x >= cnt_x);
      default:                     req_fail = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_fail) begin
            state_nxt = S_RESP;
          end else begin
            case (in_op)
              OP_PUSH_FRONT, OP_PUSH_BACK: state_nxt = S_INS_RD;
              OP_POP_FRONT, OP_POP_BACK:   state_nxt = S_UNL_RD;
              OP_INSERT:                   state_nxt = at_end ? S_INS_RD : S_WALK;
              OP_REMOVE:                   state_nxt = S_WALK;
              OP_SEARCH:                   state_nxt = S_SRCH;
              default:                     state_nxt = S_RESP;
            endcase
          end
        end
      end
      S_WALK: begin
        if (walk_hit) begin
          if (mode_r == OP_INSERT) begin
            state_nxt = S_INS_RD;
          end else begin
            state_nxt = (cur_eff < NULL_P) ? S_UNL_RD : S_RESP;
          end
        end
      end
      S_SRCH: begin
        if ((!first_r && val_q == val_r) || cur_eff >= NULL_P || i_r == NULL_P) begin
          state_nxt = S_RESP;
        end
      end
      S_INS_RD:    state_nxt = S_INS_ALLOC;
      S_INS_ALLOC: state_nxt = S_INS_LINK;
      S_INS_LINK:  state_nxt = S_RESP;
      S_UNL_RD:    state_nxt = S_UNL_FIX;
      S_UNL_FIX:   state_nxt = S_RESP;
      S_RESP: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    cur_nxt   = cur_r;
    i_nxt     = i_r;
    bef_nxt   = bef_r;
    n_nxt     = n_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    ft_nxt    = ft_r;
    lw_nxt    = lw_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    ok_nxt    = ok_r;
    found_nxt = found_r;
    rd_addr     = cur_r[AW-1:0];
    stk_rd_addr = top[AW-1:0];
    val_we = 1'b0;
    nxt_we = 1'b0;
    prv_we = 1'b0;
    stk_we = 1'b0;
    val_wa = n_r;
    nxt_wa = n_r;
    prv_wa = n_r;
    stk_wa = ft_r[AW-1:0];
    nxt_wd = cur_r;
    prv_wd = bef_link;
    stk_wd = cur_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt  = in_op;
          pos_nxt   = in_ch.position;
          val_nxt   = DATA_WIDTH'(in_ch.item_value);
          i_nxt     = '0;
          first_nxt = 1'b1;
          ok_nxt    = !req_fail;
          found_nxt = 1'b0;
          case (in_op)
            OP_PUSH_BACK: cur_nxt = NULL_P;
            OP_POP_BACK:  cur_nxt = tail_r;
            OP_INSERT:    cur_nxt = at_end ? NULL_P : head_r;
            OP_CLEAR: begin
              head_nxt = NULL_P;
              tail_nxt = NULL_P;
              cnt_nxt  = '0;
              ft_nxt   = NULL_P;
              lw_nxt   = NULL_P;
            end
            default:      cur_nxt = head_r;
          endcase
        end
      end
      S_WALK: begin
        if (walk_hit) begin
          cur_nxt = cur_eff;
          if (mode_r != OP_INSERT && cur_eff >= NULL_P) begin
            ok_nxt = 1'b0;
          end
        end else begin
          rd_addr   = cur_eff[AW-1:0];
          i_nxt     = i_r + PW'(1);
          first_nxt = 1'b0;
        end
      end
      S_SRCH: begin
        if (!first_r && val_q == val_r) begin
          found_nxt = 1'b1;
        end else if (cur_eff < NULL_P && i_r != NULL_P) begin
          rd_addr   = cur_eff[AW-1:0];
          i_nxt     = i_r + PW'(1);
          first_nxt = 1'b0;
        end
      end
      S_INS_ALLOC: begin
        n_nxt   = new_node;
        bef_nxt = bef_link;
        val_we  = 1'b1;
        nxt_we  = 1'b1;
        prv_we  = 1'b1;
        val_wa  = new_node;
        nxt_wa  = new_node;
        prv_wa  = new_node;
      end
      S_INS_LINK: begin
        if (bef_r < NULL_P) begin
          nxt_we = 1'b1;
          nxt_wa = bef_r[AW-1:0];
          nxt_wd = PW'(n_r);
        end else begin
          head_nxt = PW'(n_r);
        end
        if (cur_r < NULL_P) begin
          prv_we = 1'b1;
          prv_wa = cur_r[AW-1:0];
          prv_wd = PW'(n_r);
        end else begin
          tail_nxt = PW'(n_r);
        end
        cnt_nxt = cnt_r + PW'(1);
        ft_nxt  = top;
        lw_nxt  = (top < lw_r) ? top : lw_r;
      end
      S_UNL_FIX: begin
        if (prv_q < NULL_P) begin
          nxt_we = 1'b1;
          nxt_wa = prv_q[AW-1:0];
          nxt_wd = after;
        end else begin
          head_nxt = after;
        end
        if (after < NULL_P) begin
          prv_we = 1'b1;
          prv_wa = after[AW-1:0];
          prv_wd = prv_q;
        end else begin
          tail_nxt = prv_q;
        end
        if (ft_r < NULL_P) begin
          stk_we = 1'b1;
          ft_nxt = ft_r + PW'(1);
        end
        cnt_nxt = cnt_r - PW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NULL_P;
      tail_r  <= NULL_P;
      ft_r    <= NULL_P;
      lw_r    <= NULL_P;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      ft_r    <= ft_nxt;
      lw_r    <= lw_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    cur_r   <= cur_nxt;
    i_r     <= i_nxt;
    bef_r   <= bef_nxt;
    n_r     <= n_nxt;
    first_r <= first_nxt;
    ok_r    <= ok_nxt;
    found_r <= found_nxt;
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_r;
    end
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_q <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    prv_q <= prv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_rd_addr];
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_RESP);
  assign out_ch.ok    = ok_r;
  assign out_ch.found = found_r;
  assign out_ch.count = CNT_W'(cnt_r);

`ifndef SYNTHESIS
  // Every node is either on the list or on the free stack.
  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (ft_r + cnt_r) == NULL_P)
    else $error("free count and element count do not cover the pool");

  // An empty list has null head and tail.
  a_empty_null: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == NULL_P && tail_r == NULL_P))
    else $error("empty list with a live head or tail");

  // The low-water mark never rises above the stack top.
  a_low_water: assert property (@(posedge clk) disable iff (!rst_n)
    lw_r <= ft_r)
    else $error("free stack low-water mark above its top");
`endif

endmodule

>>> test/doubly_linked_list_engine_test.sv
module doubly_linked_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dll_pkg::*;

  localparam int CAP = 64;

  typedef struct packed {
    op_t                     mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } request_t;

  typedef struct packed {
    logic             ok;
    logic             found;
    logic [CNT_W-1:0] count;
  } response_t;

  logic clk;
  logic rst_n;

  dll_in_if  req_ch ();
  dll_out_if rsp_ch ();

  doubly_linked_list_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (rsp_ch.source)
  );

  // The list is mirrored as a plain ordered queue of values. Only the count
  // and the contents matter for the results, so node numbers are not tracked.
  logic signed [VAL_W-1:0] list_mirror[$];
  request_t  pending_requests[$];
  response_t expected_responses[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the response to one request and updates the mirror.
  function automatic response_t apply_request(request_t r);
    response_t rsp;
    int p;
    rsp = '0;
    p = int'(r.position);
    case (r.mode)
      OP_PUSH_FRONT: if (list_mirror.size() < CAP) begin
        list_mirror.push_front(r.item_value);
        rsp.ok = 1'b1;
      end
      OP_PUSH_BACK: if (list_mirror.size() < CAP) begin
        list_mirror.push_back(r.item_value);
        rsp.ok = 1'b1;
      end
      OP_POP_FRONT: if (list_mirror.size() > 0) begin
        void'(list_mirror.pop_front());
        rsp.ok = 1'b1;
      end
      OP_POP_BACK: if (list_mirror.size() > 0) begin
        void'(list_mirror.pop_back());
        rsp.ok = 1'b1;
      end
      OP_INSERT: if (list_mirror.size() < CAP && p <= list_mirror.size()) begin
        list_mirror.insert(p, r.item_value);
        rsp.ok = 1'b1;
      end
      OP_REMOVE: if (p < list_mirror.size()) begin
        list_mirror.delete(p);
        rsp.ok = 1'b1;
      end
      OP_SEARCH: begin
        rsp.ok = 1'b1;
        foreach (list_mirror[i]) if (list_mirror[i] == r.item_value) rsp.found = 1'b1;
      end
      default: begin
        list_mirror.delete();
        rsp.ok = 1'b1;
      end
    endcase
    rsp.count = CNT_W'(list_mirror.size());
    return rsp;
  endfunction

  function automatic request_t make_request(op_t m, int pos, logic [VAL_W-1:0] v);
    request_t r;
    r.mode = m;
    r.position = POS_W'(pos);
    r.item_value = v;
    return r;
  endfunction

  // Values are drawn from a small set half of the time, so that searches
  // both hit and miss.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(1, 0) == 1) return VAL_W'($urandom_range(7, 0));
    return $urandom();
  endfunction

  // Random request, biased by the fill bias handed in so that the list
  // swings between empty and full. Positions stay mostly within 0 to CAP.
  function automatic request_t random_request(int fill_bias);
    op_t m;
    int pos;
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < fill_bias) m = op_t'($urandom_range(1, 0));
    else if (roll < fill_bias + 10) m = OP_INSERT;
    else if (roll < 60) m = op_t'($urandom_range(3, 2));
    else if (roll < 75) m = OP_REMOVE;
    else if (roll < 97) m = OP_SEARCH;
    else if (roll < 99) m = OP_INSERT;
    else m = OP_CLEAR;
    if ($urandom_range(9, 0) == 0) pos = $urandom_range(127, 0);
    else pos = $urandom_range(CAP, 0);
    return make_request(m, pos, pick_value());
  endfunction

  // Driver: one beat per handshake, with random idle cycles between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid && req_ch.ready)
        expected_responses.push_back(apply_request(pending_requests.pop_front()));
      if (pending_requests.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= pending_requests[0].mode;
        req_ch.position   <= pending_requests[0].position;
        req_ch.item_value <= pending_requests[0].item_value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares every accepted response beat with the oldest expectation.
  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected response beat: ok=%b found=%b count=%0d",
                     rsp_ch.ok, rsp_ch.found, rsp_ch.count);
        end else begin
          want = expected_responses.pop_front();
          if (rsp_ch.ok !== want.ok || rsp_ch.found !== want.found ||
              rsp_ch.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected ok=%b found=%b count=%0d, got ok=%b found=%b count=%0d",
                       want.ok, want.found, want.count,
                       rsp_ch.ok, rsp_ch.found, rsp_ch.count);
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Hands the phase's requests to the driver and waits until all of them
  // have gone through and been answered.
  task automatic run_phase(int n, int idle_pct, int stall_pct);
    int bias;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    // The fill bias flips between growing and shrinking in stretches.
    bias = 55;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) bias = ($urandom_range(1, 0) == 1) ? 55 : 25;
      // The bias is applied against a mirror length that is not known yet,
      // so a stretch is long enough to fill or drain the pool.
      pending_requests.push_back(random_request(bias));
    end
    while (pending_requests.size() > 0 || req_ch.valid || expected_responses.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [VAL_W-1:0] extremes[4];
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode = OP_PUSH_FRONT;
    req_ch.position = '0;
    req_ch.item_value = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty-list failures, every operation, value extremes,
    // bad positions, insert at the count, and a clear.
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    pending_requests.push_back(make_request(OP_POP_FRONT, 0, '0));
    pending_requests.push_back(make_request(OP_POP_BACK, 0, '0));
    pending_requests.push_back(make_request(OP_REMOVE, 0, '0));
    pending_requests.push_back(make_request(OP_SEARCH, 0, '0));
    pending_requests.push_back(make_request(OP_INSERT, 1, 32'h5));
    pending_requests.push_back(make_request(OP_INSERT, 0, extremes[0]));
    pending_requests.push_back(make_request(OP_PUSH_FRONT, 0, extremes[1]));
    pending_requests.push_back(make_request(OP_PUSH_BACK, 0, extremes[2]));
    pending_requests.push_back(make_request(OP_INSERT, 3, extremes[3]));
    pending_requests.push_back(make_request(OP_INSERT, 2, 32'h1234_5678));
    pending_requests.push_back(make_request(OP_SEARCH, 0, extremes[0]));
    pending_requests.push_back(make_request(OP_SEARCH, 0, 32'h1234_5679));
    pending_requests.push_back(make_request(OP_REMOVE, 5, '0));
    pending_requests.push_back(make_request(OP_REMOVE, 127, '0));
    pending_requests.push_back(make_request(OP_INSERT, 127, '1));
    pending_requests.push_back(make_request(OP_REMOVE, 4, '0));
    pending_requests.push_back(make_request(OP_REMOVE, 1, '0));
    pending_requests.push_back(make_request(OP_POP_FRONT, 0, '0));
    pending_requests.push_back(make_request(OP_POP_BACK, 0, '0));
    pending_requests.push_back(make_request(OP_CLEAR, 0, '0));
    pending_requests.push_back(make_request(OP_SEARCH, 0, '0));
    // Fill the pool to capacity, then try one push and one insert more.
    for (int i = 0; i < CAP; i++)
      pending_requests.push_back(make_request(OP_PUSH_BACK, 0, VAL_W'(i)));
    pending_requests.push_back(make_request(OP_PUSH_FRONT, 0, '0));
    pending_requests.push_back(make_request(OP_INSERT, 10, '0));
    pending_requests.push_back(make_request(OP_SEARCH, 0, VAL_W'(CAP - 1)));
    pending_requests.push_back(make_request(OP_REMOVE, CAP - 1, '0));
    pending_requests.push_back(make_request(OP_INSERT, CAP - 1, 32'hA5A5_5A5A));
    pending_requests.push_back(make_request(OP_CLEAR, 0, '0));
    while (pending_requests.size() > 0 || req_ch.valid || expected_responses.size() > 0)
      @(posedge clk);

    // Random phases under different pressure on each side.
    run_phase(500, 0, 0);
    run_phase(500, 61, 0);
    run_phase(500, 0, 61);
    run_phase(500, 21, 21);

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Safety net: a run that hangs is ended as a failure.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
src/dll_pkg.sv
src/dll_ifs.sv
src/doubly_linked_list_engine.sv
test/doubly_linked_list_engine_test.sv
